[rtl/core/rltn_pkg.sv]
// Shared types, character constants and helpers for the radix literal converter.
`default_nettype none
package rltn_pkg;

   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;

   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;
   localparam logic [4:0] RADIX_TEN   = 5'd10;
   localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

   localparam int MANTISSA_W = 64;
   localparam int FRACTION_W = 6;
   localparam int PRODUCT_W  = MANTISSA_W + 5;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_CHAR     = 2'd1,
      STATUS_RADIX        = 2'd2,
      STATUS_SECOND_POINT = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [4:0] radix;
      logic       last_char;
   } item_type;

   typedef struct packed {
      logic       is_point;
      logic       is_bad;
      logic       is_upper;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic [MANTISSA_W-1:0] mantissa;
      logic [FRACTION_W-1:0] fraction_digits;
      logic                  overflowed;
      status_type            status;
   } result_type;

   function automatic logic [4:0] clamp_radix(input logic [4:0] radix);
      logic [4:0] r;
      r = radix;
      if (radix < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/rltn_classify.sv]
// Character decoder: point, digit value, upper-case hex letter or invalid.
`default_nettype none
module rltn_classify (
   input  wire logic [7:0]                   char_code,
   output rltn_pkg::char_class_type          char_class
);

   always_comb begin
      char_class          = '0;
      char_class.is_point = (char_code == rltn_pkg::CHAR_POINT);
      if (char_code >= rltn_pkg::CHAR_ZERO && char_code <= rltn_pkg::CHAR_NINE) begin
         char_class.digit = 4'(char_code - rltn_pkg::CHAR_ZERO);
      end else if (char_code >= rltn_pkg::CHAR_LOW_A && char_code <= rltn_pkg::CHAR_LOW_F) begin
         char_class.digit = 4'(char_code - rltn_pkg::CHAR_LOW_A) + rltn_pkg::HEX_LETTER_BASE;
      end else if (char_code >= rltn_pkg::CHAR_UP_A && char_code <= rltn_pkg::CHAR_UP_F) begin
         char_class.is_upper = 1'b1;
      end else if (!char_class.is_point) begin
         char_class.is_bad = 1'b1;
      end
   end

endmodule
`default_nettype wire

[rtl/core/rltn_accum.sv]
// Literal state: saturating multiply-add accumulator, fraction count and error tracking.
`default_nettype none
module rltn_accum #(
   parameter int MAX_FRACTION_DIGITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire rltn_pkg::item_type       item,
   input  wire rltn_pkg::char_class_type char_class,
   output rltn_pkg::result_type          result
);

   localparam logic [rltn_pkg::FRACTION_W-1:0] FRAC_CAP =
      rltn_pkg::FRACTION_W'(MAX_FRACTION_DIGITS);

   logic [rltn_pkg::MANTISSA_W-1:0] acc_ff, acc_in;
   logic [rltn_pkg::FRACTION_W-1:0] frac_ff, frac_in;
   logic                            point_ff, point_in;
   rltn_pkg::status_type            class_err_ff, class_err_in;
   logic                            range_err_ff, range_err_in;
   logic                            sat_ff, sat_in;
   logic [4:0]                      radix_ff, radix_in;
   logic                            mid_ff;
   logic [4:0]                      radix_cur;
   logic [rltn_pkg::PRODUCT_W-1:0]  product;

   assign radix_cur = mid_ff ? radix_ff : rltn_pkg::clamp_radix(item.radix);
   assign product   = rltn_pkg::PRODUCT_W'(acc_ff) * rltn_pkg::PRODUCT_W'(radix_cur)
                    + rltn_pkg::PRODUCT_W'(char_class.digit);

   always_comb begin
      acc_in       = acc_ff;
      frac_in      = frac_ff;
      point_in     = point_ff;
      class_err_in = class_err_ff;
      range_err_in = range_err_ff;
      sat_in       = sat_ff;
      radix_in     = radix_cur;
      if (char_class.is_point) begin
         if (radix_cur != rltn_pkg::RADIX_TEN) begin
            if (class_err_ff == rltn_pkg::STATUS_OK) begin
               class_err_in = rltn_pkg::STATUS_RADIX;
            end
         end else if (point_ff) begin
            if (class_err_ff == rltn_pkg::STATUS_OK) begin
               class_err_in = rltn_pkg::STATUS_SECOND_POINT;
            end
         end else begin
            point_in = 1'b1;
         end
      end else if (char_class.is_bad) begin
         if (class_err_ff == rltn_pkg::STATUS_OK) begin
            class_err_in = rltn_pkg::STATUS_BAD_CHAR;
         end
      end else if (char_class.is_upper || 5'(char_class.digit) >= radix_cur) begin
         range_err_in = 1'b1;
      end else if (point_ff && frac_ff >= FRAC_CAP) begin
         sat_in = 1'b1;
      end else begin
         if (point_ff) begin
            frac_in = frac_ff + 1'b1;
         end
         if (product[rltn_pkg::PRODUCT_W-1:rltn_pkg::MANTISSA_W] != '0) begin
            acc_in = '1;
            sat_in = 1'b1;
         end else begin
            acc_in = product[rltn_pkg::MANTISSA_W-1:0];
         end
      end
   end

   always_comb begin
      result.mantissa        = acc_in;
      result.fraction_digits = frac_in;
      result.overflowed      = sat_in;
      if (class_err_in != rltn_pkg::STATUS_OK) begin
         result.status = class_err_in;
      end else if (range_err_in) begin
         result.status = rltn_pkg::STATUS_RADIX;
      end else begin
         result.status = rltn_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_char)) begin
         acc_ff       <= '0;
         frac_ff      <= '0;
         point_ff     <= 1'b0;
         class_err_ff <= rltn_pkg::STATUS_OK;
         range_err_ff <= 1'b0;
         sat_ff       <= 1'b0;
         radix_ff     <= rltn_pkg::RADIX_TEN;
         mid_ff       <= 1'b0;
      end else if (step) begin
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         point_ff     <= point_in;
         class_err_ff <= class_err_in;
         range_err_ff <= range_err_in;
         sat_ff       <= sat_in;
         radix_ff     <= radix_in;
         mid_ff       <= 1'b1;
      end
   end

   a_frac_capped: assert property (@(posedge clock) disable iff (reset)
      frac_ff <= FRAC_CAP)
      else $error("fraction count above cap");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !mid_ff |-> (acc_ff == '0 && frac_ff == '0 && !point_ff && !sat_ff))
      else $error("literal state not cleared between literals");

   a_point_radix_ten: assert property (@(posedge clock) disable iff (reset)
      point_ff |-> (radix_ff == rltn_pkg::RADIX_TEN))
      else $error("point accepted outside radix ten");

   a_frac_needs_point: assert property (@(posedge clock) disable iff (reset)
      (frac_ff != '0) |-> point_ff)
      else $error("fraction digits counted without a point");

   a_radix_in_range: assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= rltn_pkg::RADIX_MIN && radix_ff <= rltn_pkg::RADIX_MAX))
      else $error("latched radix out of range");

endmodule
`default_nettype wire

[rtl/core/radix_literal_to_number_top.sv]
// Top level of the radix literal converter: input register, accumulator and result register.
`default_nettype none
// Converts a numeric literal, one character per item, into a saturating 64-bit mantissa,
// a count of fraction digits, an overflow flag and a status. The radix is sampled with the
// first character of each literal; one result item follows the item marked last_char.
// Throughput is one character per cycle unless a last character waits on a full result
// register; the accumulator's combinational multiply-add by the radix sets this rate. An
// accepted item is registered, then processed; a last character's result goes to the
// result register and rsp_valid. That register lets a new character be accepted while
// a result waits to be taken; a last character waits only while that register is full.
module radix_literal_to_number_top #(
   parameter int MAX_FRACTION_DIGITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [4:0]  req_radix,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_mantissa,
   output logic [5:0]       rsp_fraction_digits,
   output logic             rsp_overflowed,
   output logic [1:0]       rsp_status
);

   logic                      in_valid_ff;
   rltn_pkg::item_type        in_item_ff;
   logic                      out_free;
   logic                      step;
   rltn_pkg::char_class_type  char_class;
   rltn_pkg::result_type      result;
   logic                      rsp_valid_ff;
   rltn_pkg::result_type      rsp_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!in_item_ff.last_char || out_free);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.char_code <= req_char_code;
         in_item_ff.radix     <= req_radix;
         in_item_ff.last_char <= req_last_char;
      end
   end

   rltn_classify u_classify (
      .char_code  (in_item_ff.char_code),
      .char_class (char_class)
   );

   rltn_accum #(
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .char_class (char_class),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_item_ff.last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_item_ff.last_char) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mantissa        = rsp_ff.mantissa;
   assign rsp_fraction_digits = rsp_ff.fraction_digits;
   assign rsp_overflowed      = rsp_ff.overflowed;
   assign rsp_status          = rsp_ff.status;

endmodule
`default_nettype wire
